[hw/rtl/spl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types and constants of the sorted priority list unit: transaction
// structs, operation and status codes, and control-state encoding.
// ----------------------------------------------------------------------------
package spl_pkg;

  localparam int VAL_W = 16;
  localparam int OCC_W = 6;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_LIST_ASC = 2'd2,
    OP_LIST_DSC = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_DEL,
    S_LIST,
    S_DONE
  } state_e_t;

  typedef struct packed {
    op_e_t            operation;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] value_out;
    logic             last;
    status_e_t        status;
    logic [OCC_W-1:0] occupancy;
  } out_t;

endpackage
`default_nettype wire

[hw/rtl/spl_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spl_ram
// Simple dual-port entry store: one write port, one read port with
// enable, registered read data that holds while the read port is idle.
// ----------------------------------------------------------------------------
module spl_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [spl_pkg::VAL_W-1:0] wr_data,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             rd_addr,
  output      logic [spl_pkg::VAL_W-1:0] rd_data
);

  logic [spl_pkg::VAL_W-1:0] mem [DEPTH];
  logic [spl_pkg::VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[hw/rtl/sorted_insert_priority_list_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_priority_list_unit
// Sequence: empty/full cases go straight to the result; insert shifts one entry
//   per cycle from the top down; list emits its results one per cycle while
//   the output is not stalled.
// Throughput: one transaction at a time; the single write port and the
//   one-result-per-cycle read stream set the rate while the output is not stalled.
// Reset: synchronous rst_n clears count, control state and output valid only.
// ----------------------------------------------------------------------------
module sorted_insert_priority_list_unit #(
  parameter int DEPTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_stall,
  input  wire spl_pkg::in_t    in_data,
  output      logic            out_valid,
  input  wire logic            out_stall,
  output      spl_pkg::out_t   out_data
);

  // Address width indexes the store; count width also holds DEPTH itself.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = spl_pkg::VAL_W;
  localparam int OW = spl_pkg::OCC_W;

  // --------------------------------------------------------------------------
  // Control and payload registers
  // --------------------------------------------------------------------------
  spl_pkg::state_e_t state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;        // stored entry count
  logic [AW-1:0]     idx_r, idx_nxt;        // entry whose data the store returns
  logic [CW-1:0]     rem_r, rem_nxt;        // list results still to emit
  logic              asc_r, asc_nxt;        // list direction
  logic [VW-1:0]     val_r, val_nxt;        // value being inserted
  logic [VW-1:0]     res_val_r, res_val_nxt;
  spl_pkg::status_e_t res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  spl_pkg::out_t     out_data_r, out_data_nxt;

  // Store port signals
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] rd_data;

  logic          in_take;
  logic          out_free;
  logic [CW-1:0] cnt_dec;
  logic [AW-1:0] top_idx;
  logic [OW-1:0] occ_now;
  logic [OW-1:0] occ_nxt;
  logic [CW+OW-1:0] occ_ext_now;
  logic [CW+OW-1:0] occ_ext_nxt;

  spl_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Accept only while idle; the output register decouples the result side,
  // so a waiting result does not hold off the next transaction.
  assign in_stall  = (state_r != spl_pkg::S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Index of the topmost stored entry (meaningful when count is nonzero).
  assign cnt_dec = cnt_r - CW'(1);
  assign top_idx = cnt_dec[AW-1:0];

  // Occupancy is the count masked to the field width.
  assign occ_ext_now = {{OW{1'b0}}, cnt_r};
  assign occ_ext_nxt = {{OW{1'b0}}, cnt_nxt};
  assign occ_now     = occ_ext_now[OW-1:0];
  assign occ_nxt     = occ_ext_nxt[OW-1:0];

  // --------------------------------------------------------------------------
  // State register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spl_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    asc_r      <= asc_nxt;
    val_r      <= val_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  // --------------------------------------------------------------------------
  // Next state and store accesses
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    asc_nxt       = asc_r;
    val_nxt       = val_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = val_r;
    rd_en         = 1'b0;
    rd_addr       = top_idx;

    case (state_r)
      spl_pkg::S_IDLE: begin
        if (in_take) begin
          val_nxt     = in_data.value;
          res_val_nxt = '0;
          res_st_nxt  = spl_pkg::ST_OK;
          case (in_data.operation)
            spl_pkg::OP_INSERT: begin
              if (cnt_r == CW'(DEPTH)) begin
                // Drop the value and flag full.
                res_st_nxt = spl_pkg::ST_FULL;
                state_nxt  = spl_pkg::S_DONE;
              end else if (cnt_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = in_data.value;
                cnt_nxt   = CW'(1);
                state_nxt = spl_pkg::S_DONE;
              end else begin
                // Walk down from the top entry, shifting up while >= value.
                rd_en     = 1'b1;
                rd_addr   = top_idx;
                idx_nxt   = top_idx;
                state_nxt = spl_pkg::S_INS;
              end
            end
            spl_pkg::OP_DELETE: begin
              if (cnt_r == '0) begin
                res_st_nxt = spl_pkg::ST_EMPTY;
                state_nxt  = spl_pkg::S_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = top_idx;
                state_nxt = spl_pkg::S_DEL;
              end
            end
            spl_pkg::OP_LIST_ASC, spl_pkg::OP_LIST_DSC: begin
              asc_nxt = (in_data.operation == spl_pkg::OP_LIST_ASC);
              if (cnt_r == '0) begin
                res_st_nxt = spl_pkg::ST_EMPTY;
                state_nxt  = spl_pkg::S_DONE;
              end else begin
                idx_nxt   = asc_nxt ? '0 : top_idx;
                rd_en     = 1'b1;
                rd_addr   = idx_nxt;
                rem_nxt   = cnt_r;
                state_nxt = spl_pkg::S_LIST;
              end
            end
            default: begin
              state_nxt = spl_pkg::S_IDLE;
            end
          endcase
        end
      end

      spl_pkg::S_INS: begin
        // rd_data holds entry idx_r; the write goes one slot higher, the next
        // read one slot lower, so the two ports never meet on one entry.
        wr_en   = 1'b1;
        wr_addr = idx_r + AW'(1);
        if (rd_data >= val_r) begin
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = spl_pkg::S_INS_HEAD;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r - AW'(1);
            idx_nxt = idx_r - AW'(1);
          end
        end else begin
          wr_data   = val_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = spl_pkg::S_DONE;
        end
      end

      spl_pkg::S_INS_HEAD: begin
        // Every stored entry was >= value: place it at the head.
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = spl_pkg::S_DONE;
      end

      spl_pkg::S_DEL: begin
        res_val_nxt = rd_data;
        cnt_nxt     = cnt_dec;
        state_nxt   = spl_pkg::S_DONE;
      end

      spl_pkg::S_LIST: begin
        // rd_data holds until the next read, so a stalled output just waits.
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.value_out = rd_data;
          out_data_nxt.last      = (rem_r == CW'(1));
          out_data_nxt.status    = spl_pkg::ST_OK;
          out_data_nxt.occupancy = occ_now;
          if (rem_r == CW'(1)) begin
            state_nxt = spl_pkg::S_IDLE;
          end else begin
            idx_nxt = asc_r ? (idx_r + AW'(1)) : (idx_r - AW'(1));
            rd_en   = 1'b1;
            rd_addr = idx_nxt;
            rem_nxt = rem_r - CW'(1);
          end
        end
      end

      spl_pkg::S_DONE: begin
        // Single closing result for insert, delete and empty list.
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.value_out = res_val_r;
          out_data_nxt.last      = 1'b1;
          out_data_nxt.status    = res_st_r;
          out_data_nxt.occupancy = occ_nxt;
          state_nxt              = spl_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = spl_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/spl_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spl_chk
// Port-level checks of the sorted priority list unit, bound to the top level.
// ----------------------------------------------------------------------------
module spl_chk #(
  parameter int DEPTH = 32
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire spl_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire spl_pkg::out_t out_data
);

  localparam logic [spl_pkg::OCC_W-1:0] FULL_OCC = spl_pkg::OCC_W'(DEPTH);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One transaction at a time: after an accept the input stalls.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // Error status closes the transaction.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != spl_pkg::ST_OK) |-> out_data.last)
    else $error("error result not marked last");

  // Full drop reports a full store.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == spl_pkg::ST_FULL)
      |-> (out_data.occupancy == FULL_OCC) && (out_data.value_out == '0))
    else $error("full status with wrong occupancy");

  // Empty status reports an empty store and no value.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == spl_pkg::ST_EMPTY)
      |-> (out_data.occupancy == '0) && (out_data.value_out == '0))
    else $error("empty status with nonzero occupancy or value");

endmodule

bind sorted_insert_priority_list_unit spl_chk #(
  .DEPTH (DEPTH)
) u_spl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
